// ----- sv/pnf_pkg.sv -----
// Shared types, character codes and the digit table of the printf number formatter.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package pnf_pkg;

    // Status codes carried with every result beat.
    localparam logic [1:0] STATUS_CHAR  = 2'd0;
    localparam logic [1:0] STATUS_DONE  = 2'd1;
    localparam logic [1:0] STATUS_ERROR = 2'd2;

    // ASCII codes that the formatter recognizes or produces.
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_X       = 8'h78;
    localparam logic [7:0] CH_D       = 8'h64;
    localparam logic [7:0] CH_U       = 8'h75;
    localparam logic [7:0] CH_C       = 8'h63;
    localparam logic [7:0] CH_P       = 8'h70;

    // floor(v / 10) == (v * RECIP10) >> RECIP10_SHIFT for every 32-bit v.
    localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;
    localparam int          RECIP10_SHIFT = 35;
    localparam logic [3:0]  HEX_LAST_IDX  = 4'd9;
    localparam logic [3:0]  HEX_PREFIX_N  = 4'd2;

    localparam logic [7:0] DIGIT_TABLE [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    typedef struct packed {
        logic [7:0]  format_char;
        logic [31:0] arg_value;
    } pnf_in_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic [1:0] status;
        logic       last_of_run;
    } pnf_out_t;

    typedef enum logic [2:0] {
        CMD_SINGLE,
        CMD_PCT_END,
        CMD_HEX,
        CMD_SDEC,
        CMD_UDEC
    } cmd_kind_t;

    // One classified item handed from the front end to the back end.
    typedef struct packed {
        cmd_kind_t   kind;
        pnf_out_t    res;
        logic [31:0] arg;
    } pnf_cmd_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_LAST,
        B_PCT,
        B_MINUS,
        B_MUL,
        B_DIG,
        B_OUT,
        B_HEX
    } back_state_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        return DIGIT_TABLE[d];
    endfunction

endpackage

`default_nettype wire

// ----- sv/printf_number_formatter.sv -----
// Top level of the printf number formatter: front end, command queue and back end.
// Depends on pnf_pkg, pnf_front, pnf_cmd_fifo and pnf_back.
//
// Usage: the block is fed one format character per input beat on fmt_item, written
// like a queue with push and full; a beat is taken on a clock edge with push high and
// full low. It answers with a run of result beats, read like a queue: while empty is
// low the oldest result sits on result, and pop with empty low takes it. The last
// beat of each run has last_of_run set. Beats that produce no output (a lone percent
// sign, anything dropped after an error) leave no trace on the result side.
//
// Timing: a beat is classified in the cycle it is accepted and lands in a short
// command queue (QUEUE_DEPTH entries). The back end works on one command at a time.
// A decimal conversion first divides, with one registered reciprocal multiply and
// one subtract per digit in the divide-by-ten loop, then sends its digits, up to
// eleven characters in a run. Input stays open until the queue is full, so short
// items pile up behind a long one.
//
// Reset clears the pending-percent and error flags, empties the queue and the output
// register. When the receiver stalls, the result is held and the back end waits with
// its next character; once the queue fills, full rises and input stops.
`timescale 1ns / 1ps
`default_nettype none

module printf_number_formatter #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire pnf_pkg::pnf_in_t fmt_item,
    output logic                  empty,
    input  wire logic             pop,
    output pnf_pkg::pnf_out_t     result
);
    import pnf_pkg::*;

    logic     q_full;
    logic     q_empty;
    logic     q_push;
    logic     cmd_pop;
    pnf_cmd_t q_cmd;
    pnf_cmd_t head_cmd;

    pnf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .fmt_item (fmt_item),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_cmd)
    );

    pnf_cmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_cmd),
        .rd_en   (cmd_pop),
        .rd_data (head_cmd),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    pnf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (q_empty),
        .cmd       (head_cmd),
        .cmd_pop   (cmd_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

    // A status beat never carries a character and always closes its run.
    a_status_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.status != STATUS_CHAR) |-> (result.last_of_run && !result.char_valid))
        else $error("status beat not last or carries a character");

    // A character beat always has its valid flag set.
    a_char_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.status == STATUS_CHAR) |-> result.char_valid)
        else $error("character beat without char_valid");

    // The back end only takes commands that are present.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> !q_empty)
        else $error("command taken from empty queue");

    // The front end never writes a full queue.
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("command written to full queue");

endmodule

`default_nettype wire

// ----- sv/pnf_front.sv -----
// Front end of the printf number formatter: accepts format beats and classifies them.
// Holds the pending-percent and aborted flags; depends on pnf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pnf_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire pnf_pkg::pnf_in_t fmt_item,
    input  wire logic             q_full,
    output logic                  q_push,
    output pnf_pkg::pnf_cmd_t     q_cmd
);
    import pnf_pkg::*;

    logic pending_reg, pending_next;
    logic aborted_reg, aborted_next;
    logic accept;
    logic produce;
    logic [7:0] c;

    assign full   = q_full;
    assign accept = push && !q_full;
    assign c      = fmt_item.format_char;
    assign q_push = accept && produce;

    always_comb
    begin
        pending_next = pending_reg;
        aborted_next = aborted_reg;
        produce      = 1'b0;
        q_cmd.kind   = CMD_SINGLE;
        q_cmd.arg    = fmt_item.arg_value;
        q_cmd.res    = '{out_char: c, char_valid: 1'b1, status: STATUS_CHAR,
                         last_of_run: 1'b1};
        priority if (aborted_reg)
        begin
            // Error already reported: drop everything up to the terminator.
            if (c == CH_NUL)
            begin
                aborted_next = 1'b0;
            end
        end
        else if (c == CH_NUL)
        begin
            produce      = 1'b1;
            q_cmd.kind   = pending_reg ? CMD_PCT_END : CMD_SINGLE;
            q_cmd.res    = '{out_char: CH_NUL, char_valid: 1'b0, status: STATUS_DONE,
                             last_of_run: 1'b1};
            pending_next = 1'b0;
            aborted_next = 1'b0;
        end
        else if (!pending_reg)
        begin
            if (c == CH_PERCENT)
            begin
                pending_next = 1'b1;
            end
            else
            begin
                produce = 1'b1;
            end
        end
        else
        begin
            pending_next = 1'b0;
            produce      = 1'b1;
            unique case (c)
                CH_PERCENT: q_cmd.res.out_char = CH_PERCENT;
                CH_C:       q_cmd.res.out_char = fmt_item.arg_value[7:0];
                CH_D:       q_cmd.kind = CMD_SDEC;
                CH_U:       q_cmd.kind = CMD_UDEC;
                CH_X, CH_P: q_cmd.kind = CMD_HEX;
                default:
                begin
                    q_cmd.res    = '{out_char: CH_NUL, char_valid: 1'b0,
                                     status: STATUS_ERROR, last_of_run: 1'b1};
                    aborted_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
            aborted_reg <= 1'b0;
        end
        else if (accept)
        begin
            pending_reg <= pending_next;
            aborted_reg <= aborted_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/pnf_cmd_fifo.sv -----
// Short command queue between the front and back ends of the printf number formatter.
// Depends on pnf_pkg for the command type.
`timescale 1ns / 1ps
`default_nettype none

module pnf_cmd_fifo #(
    parameter int DEPTH = 2
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire pnf_pkg::pnf_cmd_t wr_data,
    input  wire logic              rd_en,
    output pnf_pkg::pnf_cmd_t      rd_data,
    output logic                   q_full,
    output logic                   q_empty
);
    import pnf_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    pnf_cmd_t         slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr, do_rd;

    assign q_full  = (count_reg == CNT_FULL);
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = slots[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slots[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- sv/pnf_back.sv -----
// Back end of the printf number formatter: expands commands into character beats.
// Holds the decimal divider, digit buffer and output register; depends on pnf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pnf_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_empty,
    input  wire pnf_pkg::pnf_cmd_t cmd,
    output logic                   cmd_pop,
    output logic                   empty,
    input  wire logic              pop,
    output pnf_pkg::pnf_out_t      result
);
    import pnf_pkg::*;

    back_state_t state_reg, state_next;
    pnf_out_t    res_reg, res_next;
    logic [31:0] mag_reg, mag_next;
    logic [28:0] q_reg, q_next;
    logic [3:0]  n_reg, n_next;
    logic [3:0]  digit_buf [10];
    logic        buf_wr;
    logic [3:0]  rem;
    logic [31:0] q_times_10;
    logic [63:0] prod;

    pnf_out_t out_reg;
    logic     out_valid_reg;
    logic     out_free;
    logic     emit_req;
    logic     emit_fire;
    pnf_out_t emit_data;

    assign out_free   = !out_valid_reg || pop;
    assign emit_fire  = emit_req && out_free;
    assign empty      = !out_valid_reg;
    assign result     = out_reg;

    assign prod       = 64'(mag_reg) * 64'(RECIP10);
    assign q_times_10 = {q_reg, 3'b000} + {2'b00, q_reg, 1'b0};
    assign rem        = 4'(mag_reg - q_times_10);

    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        mag_next   = mag_reg;
        q_next     = q_reg;
        n_next     = n_reg;
        cmd_pop    = 1'b0;
        buf_wr     = 1'b0;
        emit_req   = 1'b0;
        emit_data  = '{out_char: CH_PERCENT, char_valid: 1'b1, status: STATUS_CHAR,
                       last_of_run: 1'b0};
        unique case (state_reg)
            B_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop  = 1'b1;
                    res_next = cmd.res;
                    mag_next = cmd.arg;
                    n_next   = '0;
                    unique case (cmd.kind)
                        CMD_SINGLE:  state_next = B_LAST;
                        CMD_PCT_END: state_next = B_PCT;
                        CMD_HEX:     state_next = B_HEX;
                        CMD_UDEC:    state_next = B_MUL;
                        CMD_SDEC:
                        begin
                            if (cmd.arg[31])
                            begin
                                mag_next   = 32'd0 - cmd.arg;
                                state_next = B_MINUS;
                            end
                            else
                            begin
                                state_next = B_MUL;
                            end
                        end
                        default:     state_next = B_IDLE;
                    endcase
                end
            end
            B_LAST:
            begin
                emit_req  = 1'b1;
                emit_data = res_reg;
                if (emit_fire)
                begin
                    state_next = B_IDLE;
                end
            end
            B_PCT:
            begin
                emit_req = 1'b1;
                if (emit_fire)
                begin
                    state_next = B_LAST;
                end
            end
            B_MINUS:
            begin
                emit_req           = 1'b1;
                emit_data.out_char = CH_MINUS;
                if (emit_fire)
                begin
                    state_next = B_MUL;
                end
            end
            B_MUL:
            begin
                q_next     = prod[63:RECIP10_SHIFT];
                state_next = B_DIG;
            end
            B_DIG:
            begin
                // Digits come out least significant first; the buffer reverses them.
                buf_wr   = 1'b1;
                mag_next = {3'b000, q_reg};
                n_next   = n_reg + 1'b1;
                state_next = (q_reg == '0) ? B_OUT : B_MUL;
            end
            B_OUT:
            begin
                emit_req              = 1'b1;
                emit_data.out_char    = digit_char(digit_buf[4'(n_reg - 4'd1)]);
                emit_data.last_of_run = (n_reg == 4'd1);
                if (emit_fire)
                begin
                    n_next = n_reg - 1'b1;
                    if (n_reg == 4'd1)
                    begin
                        state_next = B_IDLE;
                    end
                end
            end
            B_HEX:
            begin
                emit_req              = 1'b1;
                emit_data.last_of_run = (n_reg == HEX_LAST_IDX);
                if (n_reg == 4'd0)
                begin
                    emit_data.out_char = CH_ZERO;
                end
                else if (n_reg == 4'd1)
                begin
                    emit_data.out_char = CH_X;
                end
                else
                begin
                    emit_data.out_char = digit_char(mag_reg[31:28]);
                end
                if (emit_fire)
                begin
                    n_next = n_reg + 1'b1;
                    if (n_reg >= HEX_PREFIX_N)
                    begin
                        mag_next = {mag_reg[27:0], 4'h0};
                    end
                    if (n_reg == HEX_LAST_IDX)
                    begin
                        state_next = B_IDLE;
                    end
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        mag_reg <= mag_next;
        q_reg   <= q_next;
        if (emit_fire)
        begin
            out_reg <= emit_data;
        end
        if (buf_wr)
        begin
            digit_buf[n_reg] <= rem;
        end
    end

endmodule

`default_nettype wire

// ----- dv/tb_printf_number_formatter.sv -----
// Self-checking testbench for printf_number_formatter: directed and random format strings.
// Depends on pnf_pkg for the beat types, status codes and character codes.
`timescale 1ns / 1ps

module tb_printf_number_formatter;
    import pnf_pkg::*;

    // Characters that the package does not name.
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_BYTE_MAX = 8'hFF;
    localparam logic [7:0] CH_S = 8'h73;

    // The random part starts no new string once this many items have been handed to the formatter.
    localparam int RANDOM_ITEMS_TOTAL = 470;
    // Cycles without any accepted beat before the run is declared hung. The slowest
    // legal wait is a long receiver stall on top of an eleven-character decimal conversion.
    localparam int WATCHDOG_LIMIT = 2000;
    // Settling time after the last expected beat, covering the longest back-end run.
    localparam int DRAIN_CYCLES = 40;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     push;
    logic     full;
    pnf_in_t  fmt_item;
    logic     empty;
    logic     pop;
    pnf_out_t result;

    // Predictor state: a percent sign awaiting its conversion, and the error latch.
    logic pct_pending;
    logic err_latched;

    // Characters and status beats that the formatter still owes, oldest first.
    pnf_out_t pending_beats[$];

    int  fail_count = 0;
    int  items_sent = 0;
    int  idle_cycles = 0;
    int  pop_hold = 0;
    // When set, neither side inserts gaps, so beats run back to back.
    bit  no_idle = 1'b0;

    printf_number_formatter dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .fmt_item (fmt_item),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

    always #10 clk = ~clk;

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Arguments lean toward the values where decimal and hex printing change shape.
    function automatic logic [31:0] pick_arg();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h7FFF_FFFF;
            4:       return 32'($urandom_range(0, 999));
            5:       return 32'h0 - 32'($urandom_range(1, 999));
            default: return $urandom;
        endcase
    endfunction

    function automatic pnf_out_t char_beat(input logic [7:0] ch);
        pnf_out_t b;
        b.out_char    = ch;
        b.char_valid  = 1'b1;
        b.status      = STATUS_CHAR;
        b.last_of_run = 1'b0;
        return b;
    endfunction

    function automatic pnf_out_t status_beat(input logic [1:0] code);
        pnf_out_t b;
        b.out_char    = CH_NUL;
        b.char_valid  = 1'b0;
        b.status      = code;
        b.last_of_run = 1'b0;
        return b;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        return (nib < 4'd10) ? CH_ZERO + 8'(nib) : CH_UPPER_A + 8'(nib) - 8'd10;
    endfunction

    // Works out the run of beats that one accepted format character causes and
    // queues it, updating the pending-percent and error flags on the way.
    task automatic predict_run(input logic [7:0] ch, input logic [31:0] arg);
        pnf_out_t    run[$];
        logic [7:0]  digits[$];
        logic [31:0] mag;
        if (err_latched) begin
            // After an error everything is swallowed; the terminator only rearms.
            if (ch == CH_NUL)
                err_latched = 1'b0;
            return;
        end
        if (ch == CH_NUL) begin
            if (pct_pending)
                run.push_back(char_beat(CH_PERCENT));
            run.push_back(status_beat(STATUS_DONE));
            pct_pending = 1'b0;
            err_latched = 1'b0;
        end else if (!pct_pending) begin
            if (ch == CH_PERCENT)
                pct_pending = 1'b1;
            else
                run.push_back(char_beat(ch));
        end else begin
            pct_pending = 1'b0;
            case (ch)
                CH_PERCENT: run.push_back(char_beat(CH_PERCENT));
                CH_C:       run.push_back(char_beat(arg[7:0]));
                CH_D, CH_U:
                begin
                    mag = arg;
                    if (ch == CH_D && arg[31])
                    begin
                        run.push_back(char_beat(CH_MINUS));
                        mag = 32'h0 - arg;
                    end
                    do
                    begin
                        digits.push_front(CH_ZERO + 8'(mag % 10));
                        mag = mag / 10;
                    end while (mag != 0);
                    foreach (digits[i])
                        run.push_back(char_beat(digits[i]));
                end
                CH_X, CH_P:
                begin
                    run.push_back(char_beat(CH_ZERO));
                    run.push_back(char_beat(CH_X));
                    for (int i = 7; i >= 0; i--)
                        run.push_back(char_beat(hex_char(arg[i*4 +: 4])));
                end
                default:
                begin
                    run.push_back(status_beat(STATUS_ERROR));
                    err_latched = 1'b1;
                end
            endcase
        end
        if (run.size() > 0)
            run[run.size() - 1].last_of_run = 1'b1;
        foreach (run[i])
            pending_beats.push_back(run[i]);
    endtask

    // Offers one format character and holds it until the formatter takes it. Push is
    // only lowered when a gap follows, so back-to-back beats never see push toggle
    // twice in one time step.
    task automatic send_char(input logic [7:0] ch, input logic [31:0] arg);
        int gap;
        push     <= 1'b1;
        fmt_item <= '{format_char: ch, arg_value: arg};
        do
            @(posedge clk);
        while (full);
        items_sent++;
        predict_run(ch, arg);
        gap = pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_conversion(input logic [7:0] spec, input logic [31:0] arg);
        send_char(CH_PERCENT, $urandom);
        send_char(spec, arg);
    endtask

    // Plain characters pass through unchanged, including the largest byte value, and the terminator closes the string.
    task automatic test_plain_chars();
        send_char(CH_UPPER_A, 32'h0);
        send_char(CH_BYTE_MAX, 32'hFFFF_FFFF);
        send_char(CH_NUL, 32'h0);
    endtask

    // Every conversion at least once, with arguments at the edges of each printing format.
    task automatic test_conversions();
        send_conversion(CH_PERCENT, 32'h1234_5678);
        send_conversion(CH_C, 32'hFFFF_FF41);
        // The most negative value prints the longest run, eleven characters.
        send_conversion(CH_D, 32'h8000_0000);
        send_conversion(CH_D, 32'h7FFF_FFFF);
        send_conversion(CH_D, 32'h0000_0000);
        send_conversion(CH_U, 32'hFFFF_FFFF);
        send_conversion(CH_X, 32'hDEAD_BEEF);
        send_conversion(CH_P, 32'h0000_0000);
        send_char(CH_NUL, 32'h0);
    endtask

    // A lone percent before the terminator, and an unknown conversion that must
    // swallow the rest of the string, terminator included.
    task automatic test_special_cases();
        send_char(CH_PERCENT, 32'h0);
        send_char(CH_NUL, 32'h0);
        send_conversion(CH_S, 32'hFFFF_FFFF);
        send_conversion(CH_D, 32'h8000_0000);
        send_char(CH_NUL, 32'h0);
    endtask

    // Random strings built mostly from well-formed pieces with random content, with
    // raw bytes and broken conversions mixed in as noise. Some strings run with no
    // gaps on either side.
    task automatic test_random_strings();
        int pieces;
        int r;
        while (items_sent < RANDOM_ITEMS_TOTAL)
        begin
            no_idle = ($urandom_range(0, 5) == 0);
            pieces = $urandom_range(1, 10);
            repeat (pieces)
            begin
                r = $urandom_range(0, 99);
                if (r < 40)
                    send_char(8'($urandom_range(1, 255)), $urandom);
                else if (r < 85)
                begin
                    case ($urandom_range(0, 5))
                        0:       send_conversion(CH_PERCENT, pick_arg());
                        1:       send_conversion(CH_C, pick_arg());
                        2:       send_conversion(CH_D, pick_arg());
                        3:       send_conversion(CH_U, pick_arg());
                        4:       send_conversion(CH_X, pick_arg());
                        default: send_conversion(CH_P, pick_arg());
                    endcase
                end
                else if (r < 93)
                    send_char(8'($urandom_range(0, 255)), $urandom);
                else
                    send_conversion(8'($urandom_range(0, 255)), $urandom);
            end
            // Most strings are terminated; the rest run on into the next one.
            if ($urandom_range(0, 9) != 0)
                send_char(CH_NUL, $urandom);
        end
        no_idle = 1'b0;
    endtask

    // Stops input, waits for every owed beat, then gives the back end time to show
    // any stray beat before the verdict.
    task automatic finish_run();
        push <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("printf_number_formatter test passed");
        else
            $display("printf_number_formatter test failed");
        $finish;
    endtask

    initial
    begin
        rst_n       = 1'b0;
        push        = 1'b0;
        fmt_item    = '0;
        pct_pending = 1'b0;
        err_latched = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_plain_chars();
        test_conversions();
        test_special_cases();
        test_random_strings();
        finish_run();
    end

    // The receiver pops freely but now and then stalls for a random stretch.
    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (pop_hold > 0)
        begin
            pop_hold <= pop_hold - 1;
            pop      <= 1'b0;
        end
        else
        begin
            pop <= 1'b1;
            if (!no_idle && $urandom_range(0, 9) == 0)
                pop_hold <= 1 + pick_gap();
        end
    end

    // Every result beat taken is compared field by field with the oldest owed beat.
    always @(posedge clk)
    begin : check_beat
        pnf_out_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_beats.size() == 0)
            begin
                $error("unexpected result beat: out_char %h char_valid %b status %0d last %b",
                       result.out_char, result.char_valid, result.status,
                       result.last_of_run);
                fail_count++;
            end
            else
            begin
                want = pending_beats.pop_front();
                if (result.out_char !== want.out_char)
                begin
                    $error("out_char: expected %h, got %h", want.out_char, result.out_char);
                    fail_count++;
                end
                if (result.char_valid !== want.char_valid)
                begin
                    $error("char_valid: expected %b, got %b",
                           want.char_valid, result.char_valid);
                    fail_count++;
                end
                if (result.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, result.status);
                    fail_count++;
                end
                if (result.last_of_run !== want.last_of_run)
                begin
                    $error("last_of_run: expected %b, got %b",
                           want.last_of_run, result.last_of_run);
                    fail_count++;
                end
            end
        end
    end

    // Ends the run if no beat moves on either side for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("printf_number_formatter test failed");
                $finish;
            end
        end
    end

endmodule

// ----- sim.f -----
sv/pnf_pkg.sv
sv/pnf_front.sv
sv/pnf_cmd_fifo.sv
sv/pnf_back.sv
sv/printf_number_formatter.sv
dv/tb_printf_number_formatter.sv
